FILE: src/tvs_pkg.sv
// Shared types, constants and register codes for the teleop velocity shaper.
// No dependencies.
`default_nettype none
package tvs_pkg;

    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 16;
    localparam int AngleW = 12;
    localparam int CmdOutW = 10;
    localparam int HeartbeatTicks = 10;
    localparam int QuotW = 10;
    localparam int NumW = 21;

    localparam logic [8:0] FwdLimitMax = 9'd350;
    localparam logic [8:0] TurnLimitMax = 9'd510;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_ESTOP  = 2'd2,
        CMD_RESUME = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_DEADZONE   = 3'd0,
        REG_FULL_SCALE = 3'd1,
        REG_MAX_FWD    = 3'd2,
        REG_MAX_TURN   = 3'd3,
        REG_FWD_STEP   = 3'd4,
        REG_TURN_STEP  = 3'd5,
        REG_TIMEOUT    = 3'd6,
        REG_INVERT     = 3'd7
    } reg_idx_t;

    // Controller to datapath
    typedef struct packed {
        logic load_fwd;   // start shaping the forward axis
        logic load_turn;  // start shaping the turn axis
        logic div_step;   // one restoring-division step
        logic finish_fwd; // capture the forward result
        logic finish_turn;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_done;
    } dp_status_t;

endpackage
`default_nettype wire

FILE: src/teleop_velocity_shaper.sv
// Top level: configuration registers, controller and shaping datapath.
// Depends on tvs_pkg, tvs_ctrl and tvs_datapath.
`default_nettype none
// A sample, emergency stop or resume word is handled on acceptance without leaving the
// idle state. A tick that shapes the held sample runs two 22-step serial divisions, one
// per axis, through one shared divider before the publish decision; a tick that stops
// uses no division. One word is in work at a time;
// a finished result waits in the output register while the next word is taken.
module teleop_velocity_shaper (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_ready,
    input  wire  [1:0]        cmd,
    input  wire signed [11:0] x_angle,
    input  wire signed [11:0] z_angle,
    output logic              out_valid,
    input  wire               out_ready,
    output logic signed [9:0] forward_speed,
    output logic signed [9:0] turn_rate,
    output logic              is_stop,
    input  wire               cfg_we,
    input  wire  [2:0]        cfg_index,
    input  wire  [15:0]       cfg_data
);
    import tvs_pkg::*;

    logic [9:0]  deadzone_reg;
    logic [10:0] fs_reg;
    logic [8:0]  maxf_reg, maxt_reg, fstep_reg, tstep_reg;
    logic [15:0] timeout_reg;
    logic [1:0]  inv_reg;
    dp_cmd_t     ctl;
    dp_status_t  sts;
    logic signed [11:0] held_x, held_z;
    logic signed [9:0]  fwd_val, turn_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg <= 10'd50;
            fs_reg <= 11'd450;
            maxf_reg <= 9'd150;
            maxt_reg <= 9'd200;
            fstep_reg <= 9'd10;
            tstep_reg <= 9'd20;
            timeout_reg <= 16'd20;
            inv_reg <= 2'd2;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_DEADZONE:   deadzone_reg <= cfg_data[9:0];
                REG_FULL_SCALE: fs_reg <= cfg_data[10:0];
                REG_MAX_FWD:    maxf_reg <= (cfg_data[8:0] > FwdLimitMax) ?
                                            FwdLimitMax : cfg_data[8:0];
                REG_MAX_TURN:   maxt_reg <= (cfg_data[8:0] > TurnLimitMax) ?
                                            TurnLimitMax : cfg_data[8:0];
                REG_FWD_STEP:   fstep_reg <= cfg_data[8:0];
                REG_TURN_STEP:  tstep_reg <= cfg_data[8:0];
                REG_TIMEOUT:    timeout_reg <= cfg_data;
                REG_INVERT:     inv_reg <= cfg_data[1:0];
                default:        deadzone_reg <= deadzone_reg;
            endcase
        end
    end

    tvs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .x_angle(x_angle), .z_angle(z_angle),
        .out_valid(out_valid), .out_ready(out_ready),
        .forward_speed(forward_speed), .turn_rate(turn_rate), .is_stop(is_stop),
        .timeout_ticks(timeout_reg),
        .ctl(ctl), .sts(sts),
        .held_x(held_x), .held_z(held_z),
        .fwd_val(fwd_val), .turn_val(turn_val)
    );

    tvs_datapath u_dp (
        .clk(clk), .rst_n(rst_n),
        .ctl(ctl), .sts(sts),
        .held_x(held_x), .held_z(held_z),
        .deadzone(deadzone_reg), .full_scale(fs_reg),
        .max_fwd(maxf_reg), .max_turn(maxt_reg),
        .fwd_step(fstep_reg), .turn_step(tstep_reg),
        .invert(inv_reg),
        .fwd_val(fwd_val), .turn_val(turn_val)
    );

endmodule
`default_nettype wire

FILE: src/tvs_datapath.sv
// Axis shaping datapath: deadzone, clamp, scale and a shared serial divider.
// Depends on tvs_pkg.
`default_nettype none
module tvs_datapath (
    input  wire                   clk,
    input  wire                   rst_n,
    input  tvs_pkg::dp_cmd_t      ctl,
    output tvs_pkg::dp_status_t   sts,
    input  wire signed [11:0]     held_x,
    input  wire signed [11:0]     held_z,
    input  wire        [9:0]      deadzone,
    input  wire        [10:0]     full_scale,
    input  wire        [8:0]      max_fwd,
    input  wire        [8:0]      max_turn,
    input  wire        [8:0]      fwd_step,
    input  wire        [8:0]      turn_step,
    input  wire        [1:0]      invert,
    output logic signed [9:0]     fwd_val,
    output logic signed [9:0]     turn_val
);
    import tvs_pkg::*;

    // Numerator 2n+d up to ~3.2e6 (22 bits); divisor 2d up to ~2.1e6 (21 bits)
    logic [21:0] rem_reg, rem_next;
    logic [21:0] dvs_reg, dvs_next;
    logic [21:0] num_reg, num_next;
    logic [QuotW-1:0] quo_reg, quo_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        zero_reg, zero_next;
    logic [8:0]  lim_reg, lim_next;
    logic [8:0]  stp_reg, stp_next;
    logic signed [9:0] fwd_reg, fwd_next, turn_reg, turn_next;

    logic signed [11:0] ang;
    logic [11:0] mag;
    logic [10:0] fs, magc;
    logic [8:0]  lim, stp;
    logic [19:0] n;
    logic [19:0] d;
    logic [22:0] trial;
    logic [18:0] v;
    logic [8:0]  vc;
    logic signed [9:0] res;

    always_comb
    begin
        ang  = ctl.load_fwd ? held_z : held_x;
        lim  = ctl.load_fwd ? max_fwd : max_turn;
        stp  = ctl.load_fwd ? fwd_step : turn_step;
        if (stp == 9'd0)
            stp = 9'd1;
        fs   = (full_scale == 11'd0) ? 11'd1 : full_scale;
        mag  = ang[11] ? 12'(-ang) : 12'(ang);
        magc = ({1'b0, fs} < mag) ? fs : mag[10:0];
        n    = 20'(magc) * 20'(lim);
        d    = 20'(fs) * 20'(stp);
        trial = '0;

        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        lim_next  = lim_reg;
        stp_next  = stp_reg;
        fwd_next  = fwd_reg;
        turn_next = turn_reg;

        if (ctl.load_fwd || ctl.load_turn)
        begin
            rem_next  = '0;
            num_next  = {1'b0, n, 1'b0} + 22'(d);
            dvs_next  = {1'b0, d, 1'b0};
            quo_next  = '0;
            cnt_next  = 5'd22;
            neg_next  = ang[11];
            zero_next = (mag < {2'b0, deadzone});
            lim_next  = lim;
            stp_next  = stp;
        end
        else if (ctl.div_step && cnt_reg != 5'd0)
        begin
            // Quotient stays below 2^10 since q*step is bounded near limit
            trial = {rem_reg, num_reg[21]};
            num_next = {num_reg[20:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = 22'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[QuotW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[21:0];
                quo_next = {quo_reg[QuotW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
        end

        v   = 19'(quo_reg) * 19'(stp_reg);
        vc  = (v > 19'(lim_reg)) ? lim_reg : v[8:0];
        if (zero_reg)
            vc = '0;
        res = neg_reg ? -$signed({1'b0, vc}) : $signed({1'b0, vc});

        if (ctl.finish_fwd)
            fwd_next = invert[0] ? -res : res;
        if (ctl.finish_turn)
            turn_next = invert[1] ? -res : res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            fwd_reg  <= '0;
            turn_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            fwd_reg  <= fwd_next;
            turn_reg <= turn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        lim_reg  <= lim_next;
        stp_reg  <= stp_next;
    end

    assign sts.div_done = (cnt_reg == 5'd0);
    assign fwd_val  = fwd_reg;
    assign turn_val = turn_reg;

`ifndef ASSERT_OFF
    a_load_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.load_fwd && ctl.load_turn))
        else $error("both axes loaded at once");
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.load_fwd || ctl.load_turn) |=> !sts.div_done)
        else $error("divider not started");
    a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.finish_fwd || ctl.finish_turn) |-> sts.div_done)
        else $error("result taken before division finished");
`endif

endmodule
`default_nettype wire

FILE: src/tvs_ctrl.sv
// Controller: item handshake, tick state, publish decision and output register.
// Depends on tvs_pkg.
`default_nettype none
module tvs_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire  [1:0]            cmd,
    input  wire signed [11:0]     x_angle,
    input  wire signed [11:0]     z_angle,
    output logic                  out_valid,
    input  wire                   out_ready,
    output logic signed [9:0]     forward_speed,
    output logic signed [9:0]     turn_rate,
    output logic                  is_stop,
    input  wire  [15:0]           timeout_ticks,
    output tvs_pkg::dp_cmd_t      ctl,
    input  tvs_pkg::dp_status_t   sts,
    output logic signed [11:0]    held_x,
    output logic signed [11:0]    held_z,
    input  wire signed [9:0]      fwd_val,
    input  wire signed [9:0]      turn_val
);
    import tvs_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_FWD    = 6'b000010,
        ST_FWAIT  = 6'b000100,
        ST_TWAIT  = 6'b001000,
        ST_DECIDE = 6'b010000,
        ST_OUT    = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic estop_reg, estop_next, have_reg, have_next, moving_reg, moving_next;
    logic [15:0] age_reg, age_next, tsp_reg, tsp_next;
    logic [1:0] stops_reg, stops_next;
    logic signed [9:0] lastf_reg, lastf_next, lastt_reg, lastt_next;
    logic signed [11:0] hx_reg, hx_next, hz_reg, hz_next;
    logic ov_reg, ov_next, stop_reg, stop_next;
    logic signed [9:0] of_reg, of_next, ot_reg, ot_next;
    logic [15:0] age_inc, tsp_inc;
    logic accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        estop_next = estop_reg;
        have_next = have_reg;
        moving_next = moving_reg;
        age_next = age_reg;
        tsp_next = tsp_reg;
        stops_next = stops_reg;
        lastf_next = lastf_reg;
        lastt_next = lastt_reg;
        hx_next = hx_reg;
        hz_next = hz_reg;
        ov_next = ov_reg;
        stop_next = stop_reg;
        of_next = of_reg;
        ot_next = ot_reg;
        ctl = '0;
        age_inc = (age_reg == 16'hFFFF) ? age_reg : age_reg + 16'd1;
        tsp_inc = (tsp_reg == 16'hFFFF) ? tsp_reg : tsp_reg + 16'd1;

        if (ov_reg && out_ready)
            ov_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_t'(cmd))
                        CMD_SAMPLE:
                        begin
                            hx_next = x_angle;
                            hz_next = z_angle;
                            have_next = 1'b1;
                            age_next = '0;
                        end
                        CMD_ESTOP:  estop_next = 1'b1;
                        CMD_RESUME: estop_next = 1'b0;
                        default:
                        begin
                            age_next = age_inc;
                            tsp_next = tsp_inc;
                            if (estop_reg || !have_reg || age_inc > timeout_ticks)
                            begin
                                if (moving_reg || stops_reg != 2'd0)
                                begin
                                    if (moving_reg)
                                    begin
                                        moving_next = 1'b0;
                                        if (estop_reg)
                                            stops_next = 2'd3;
                                    end
                                    else
                                        stops_next = stops_reg - 2'd1;
                                    lastf_next = '0;
                                    lastt_next = '0;
                                    tsp_next = '0;
                                    state_next = ST_OUT;
                                end
                            end
                            else
                                state_next = ST_FWD;
                        end
                    endcase
                end
            end
            ST_FWD:
            begin
                ctl.load_fwd = 1'b1;
                state_next = ST_FWAIT;
            end
            ST_FWAIT:
            begin
                ctl.div_step = 1'b1;
                if (sts.div_done)
                begin
                    ctl.div_step = 1'b0;
                    ctl.finish_fwd = 1'b1;
                    ctl.load_turn = 1'b1;
                    state_next = ST_TWAIT;
                end
            end
            ST_TWAIT:
            begin
                ctl.div_step = 1'b1;
                if (sts.div_done)
                begin
                    ctl.div_step = 1'b0;
                    ctl.finish_turn = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_IDLE;
                if (fwd_val == 10'sd0 && turn_val == 10'sd0)
                begin
                    if (moving_reg)
                    begin
                        moving_next = 1'b0;
                        lastf_next = '0;
                        lastt_next = '0;
                        tsp_next = '0;
                        state_next = ST_OUT;
                    end
                end
                else if (fwd_val != lastf_reg || turn_val != lastt_reg ||
                         tsp_reg >= 16'(HeartbeatTicks))
                begin
                    lastf_next = fwd_val;
                    lastt_next = turn_val;
                    tsp_next = '0;
                    moving_next = 1'b1;
                    stops_next = 2'd3;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // wait for the previous word to leave; a stop always leaves moving clear
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    of_next = lastf_reg;
                    ot_next = lastt_reg;
                    stop_next = !moving_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            estop_reg <= 1'b0;
            have_reg <= 1'b0;
            moving_reg <= 1'b0;
            age_reg <= '0;
            tsp_reg <= 16'hFFFF;
            stops_reg <= '0;
            lastf_reg <= '0;
            lastt_reg <= '0;
            hx_reg <= '0;
            hz_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            estop_reg <= estop_next;
            have_reg <= have_next;
            moving_reg <= moving_next;
            age_reg <= age_next;
            tsp_reg <= tsp_next;
            stops_reg <= stops_next;
            lastf_reg <= lastf_next;
            lastt_reg <= lastt_next;
            hx_reg <= hx_next;
            hz_reg <= hz_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stop_reg <= stop_next;
        of_reg <= of_next;
        ot_reg <= ot_next;
    end

    assign out_valid = ov_reg;
    assign forward_speed = of_reg;
    assign turn_rate = ot_reg;
    assign is_stop = stop_reg;
    assign held_x = hx_reg;
    assign held_z = hz_reg;

`ifndef ASSERT_OFF
    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && stop_reg) |-> (of_reg == 10'sd0 && ot_reg == 10'sd0))
        else $error("stop word carries nonzero speed");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> (ov_reg && $stable(of_reg) && $stable(ot_reg)))
        else $error("pending word changed");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input taken while busy");
`endif

endmodule
`default_nettype wire

FILE: sim/tvs_scoreboard.sv
// Watches the word and result channels of the velocity shaper, predicts each published
// command and compares it with the one seen. Depends on tvs_pkg.
`timescale 1ns / 1ps
module tvs_scoreboard (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    input  wire               in_ready,
    input  wire  [1:0]        cmd,
    input  wire signed [11:0] x_angle,
    input  wire signed [11:0] z_angle,
    input  wire               out_valid,
    input  wire               out_ready,
    input  wire signed [9:0]  forward_speed,
    input  wire signed [9:0]  turn_rate,
    input  wire               is_stop,
    input  wire               cfg_we,
    input  wire  [2:0]        cfg_index,
    input  wire  [15:0]       cfg_data,
    output int                fail_count,
    output int                pending
);
    import tvs_pkg::*;

    typedef struct packed {
        logic signed [9:0] fwd;
        logic signed [9:0] trn;
        logic              stop;
    } velocity_t;

    velocity_t expected_cmds[$];

    int unsigned dz, fs_angle, fwd_lim, trn_lim, fwd_stp, trn_stp, tmo, inv;
    bit estop, have_sample, moving;
    int held_x, held_z, last_fwd, last_trn;
    int unsigned age, pub_age, stops_left;

    function automatic int shape(int angle, int unsigned limit, int unsigned step);
        int unsigned mag, fs, st, n, d, q, v;
        mag = angle < 0 ? -angle : angle;
        fs = fs_angle != 0 ? fs_angle : 1;
        st = step != 0 ? step : 1;
        if (mag < dz)
            return 0;
        if (mag > fs)
            mag = fs;
        n = mag * limit;
        d = fs * st;
        q = (2 * n + d) / (2 * d);
        v = q * st;
        if (v > limit)
            v = limit;
        return angle < 0 ? -int'(v) : int'(v);
    endfunction

    task automatic push_stop();
        velocity_t e;
        last_fwd = 0;
        last_trn = 0;
        pub_age = 0;
        e.fwd = '0;
        e.trn = '0;
        e.stop = 1'b1;
        expected_cmds.push_back(e);
    endtask

    task automatic stop_or_drain();
        if (moving)
        begin
            moving = 0;
            push_stop();
        end
        else if (stops_left > 0)
        begin
            stops_left--;
            push_stop();
        end
    endtask

    task automatic predict_word(cmd_t c, logic signed [11:0] xa, logic signed [11:0] za);
        int f, t;
        velocity_t e;
        case (c)
            CMD_SAMPLE:
            begin
                held_x = xa;
                held_z = za;
                have_sample = 1;
                age = 0;
            end
            CMD_ESTOP: estop = 1;
            CMD_RESUME: estop = 0;
            default:
            begin
                if (age < 16'hFFFF)
                    age++;
                if (pub_age < 16'hFFFF)
                    pub_age++;
                if (estop)
                begin
                    if (moving)
                    begin
                        moving = 0;
                        stops_left = 3;
                        push_stop();
                    end
                    else if (stops_left > 0)
                    begin
                        stops_left--;
                        push_stop();
                    end
                end
                else if (!have_sample || age > tmo)
                    stop_or_drain();
                else
                begin
                    f = shape(held_z, fwd_lim, fwd_stp);
                    t = shape(held_x, trn_lim, trn_stp);
                    if (inv[0])
                        f = -f;
                    if (inv[1])
                        t = -t;
                    if (f == 0 && t == 0)
                    begin
                        if (moving)
                        begin
                            moving = 0;
                            push_stop();
                        end
                    end
                    else if (f != last_fwd || t != last_trn || pub_age >= HeartbeatTicks)
                    begin
                        last_fwd = f;
                        last_trn = t;
                        pub_age = 0;
                        moving = 1;
                        stops_left = 3;
                        e.fwd = 10'(f);
                        e.trn = 10'(t);
                        e.stop = 1'b0;
                        expected_cmds.push_back(e);
                    end
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        velocity_t e;
        if (!rst_n)
        begin
            dz = 50; fs_angle = 450; fwd_lim = 150; trn_lim = 200;
            fwd_stp = 10; trn_stp = 20; tmo = 20; inv = 2;
            estop = 0; have_sample = 0; moving = 0;
            held_x = 0; held_z = 0; age = 0; pub_age = 16'hFFFF;
            stops_left = 0; last_fwd = 0; last_trn = 0;
            fail_count <= 0;
            expected_cmds.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_DEADZONE:   dz = 32'(cfg_data[9:0]);
                    REG_FULL_SCALE: fs_angle = 32'(cfg_data[10:0]);
                    REG_MAX_FWD:    fwd_lim = cfg_data[8:0] > 350 ? 350 : 32'(cfg_data[8:0]);
                    REG_MAX_TURN:   trn_lim = cfg_data[8:0] > 510 ? 510 : 32'(cfg_data[8:0]);
                    REG_FWD_STEP:   fwd_stp = 32'(cfg_data[8:0]);
                    REG_TURN_STEP:  trn_stp = 32'(cfg_data[8:0]);
                    REG_TIMEOUT:    tmo = 32'(cfg_data);
                    REG_INVERT:     inv = 32'(cfg_data[1:0]);
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_cmds.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result: fwd %0d turn %0d stop %0b",
                                 forward_speed, turn_rate, is_stop);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_cmds.pop_front();
                    if (e.fwd !== forward_speed || e.trn !== turn_rate || e.stop !== is_stop)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: exp fwd %0d turn %0d stop %0b, got %0d %0d %0b",
                                     e.fwd, e.trn, e.stop, forward_speed, turn_rate, is_stop);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // predict after popping so a same-edge result is not matched against it
            if (in_valid && in_ready)
                predict_word(cmd_t'(cmd), x_angle, z_angle);
            pending <= expected_cmds.size();
        end
    end

endmodule

FILE: sim/teleop_velocity_shaper_tb.sv
// Stimulus and verdict for the teleop velocity shaper.
// Depends on tvs_pkg, teleop_velocity_shaper and tvs_scoreboard.
`timescale 1ns / 1ps
module teleop_velocity_shaper_tb;
    import tvs_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        cmd;
    logic signed [11:0] x_angle;
    logic signed [11:0] z_angle;
    logic              out_valid;
    logic              out_ready;
    logic signed [9:0] forward_speed;
    logic signed [9:0] turn_rate;
    logic              is_stop;
    logic              cfg_we;
    logic [2:0]        cfg_index;
    logic [15:0]       cfg_data;
    int                fail_count;
    int                pending;

    bit stall_free;
    bit hold_off;
    bit words_done;
    int idle_cycles;

    teleop_velocity_shaper dut (.*);

    tvs_scoreboard checker_i (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_off = 0;
            end
            out_ready <= stall_free || ($urandom_range(99) >= 33);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (idle_cycles > 5000)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // valid stays high after the accept until the next word or a drain replaces it
    task automatic send_word(cmd_t c, logic signed [11:0] xa, logic signed [11:0] za);
        while (!stall_free && $urandom_range(99) < 33)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        x_angle <= xa;
        z_angle <= za;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, int unsigned val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 16'(val);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic signed [11:0] rand_angle();
        case ($urandom_range(5))
            0: return 12'(-1800 + $urandom_range(3600));
            1: return 12'($urandom_range(120) - 60);
            2: return $urandom_range(1) ? 12'sd1800 : -12'sd1800;
            3: return 12'($urandom);
            default: return 12'($urandom_range(1000) - 500);
        endcase
    endfunction

    task automatic random_phase(int count);
        int k;
        cmd_t c;
        for (k = 0; k < count; k++)
        begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4: c = CMD_SAMPLE;
                5: c = CMD_ESTOP;
                6: c = CMD_RESUME;
                default: c = CMD_TICK;
            endcase
            send_word(c, rand_angle(), rand_angle());
        end
    endtask

    task automatic random_config(bit extreme);
        write_reg(REG_DEADZONE, extreme ? 900 * $urandom_range(1) : $urandom_range(200));
        write_reg(REG_FULL_SCALE, extreme ? ($urandom_range(1) ? 2047 : 0)
                                          : $urandom_range(1800));
        write_reg(REG_MAX_FWD, extreme ? ($urandom_range(1) ? 511 : 0) : $urandom_range(350));
        write_reg(REG_MAX_TURN, extreme ? ($urandom_range(1) ? 511 : 0) : $urandom_range(510));
        write_reg(REG_FWD_STEP, extreme ? ($urandom_range(1) ? 511 : 0) : $urandom_range(1, 60));
        write_reg(REG_TURN_STEP, extreme ? ($urandom_range(1) ? 511 : 0) : $urandom_range(1, 60));
        write_reg(REG_TIMEOUT, extreme ? ($urandom_range(1) ? 65535 : 0) : $urandom_range(40));
        write_reg(REG_INVERT, $urandom_range(3));
    endtask

    initial
    begin
        int ph;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_TICK;
        x_angle = '0;
        z_angle = '0;
        cfg_we = 1'b0;
        cfg_index = REG_DEADZONE;
        cfg_data = '0;
        stall_free = 0;
        hold_off = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: no sample, extremes, estop, heartbeat, zero command
        send_word(CMD_TICK, '0, '0);
        send_word(CMD_SAMPLE, 12'sd1800, -12'sd1800);
        send_word(CMD_TICK, '0, '0);
        send_word(CMD_SAMPLE, 12'sh800, 12'sd2047);
        send_word(CMD_TICK, '0, '0);
        send_word(CMD_ESTOP, '0, '0);
        send_word(CMD_SAMPLE, 12'sd300, 12'sd300);
        repeat (5) send_word(CMD_TICK, '0, '0);
        send_word(CMD_RESUME, '0, '0);
        repeat (12) send_word(CMD_TICK, '0, '0);
        send_word(CMD_SAMPLE, 12'sd10, -12'sd10);
        send_word(CMD_TICK, '0, '0);
        drain();
        write_reg(REG_MAX_FWD, 16'hFFFF);

        for (ph = 0; ph < 8; ph++)
        begin
            random_config(ph == 2 || ph == 5);
            stall_free = (ph == 3);
            if (ph == 4)
                hold_off = 1;
            // keep samples fresh so shaping is reached in most ticks
            random_phase(ph == 4 ? 100 : 170);
            // sender waits for all results before the next setting
            drain();
        end
        stall_free = 0;
        write_reg(REG_FULL_SCALE, 0);
        write_reg(REG_FWD_STEP, 0);
        write_reg(REG_TURN_STEP, 0);
        write_reg(REG_TIMEOUT, 65535);
        write_reg(REG_DEADZONE, 0);
        random_phase(100);
        drain();

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
